// File: design/bcd_rtc_with_register_memory_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the BCD real-time clock block
// Shared concurrent checks, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef BCD_RTC_WITH_REGISTER_MEMORY_ASSERT_SVH
`define BCD_RTC_WITH_REGISTER_MEMORY_ASSERT_SVH

// Same-cycle implication.
`define BRTC_ASSERT_SAME(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define BRTC_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: design/brtc_pkg.sv
// ---------------------------------------------------------------------------
// brtc_pkg
// Types, codes and BCD helpers for the BCD real-time clock block.
// ---------------------------------------------------------------------------
package brtc_pkg;

    // Register memory: power-of-two size, pointer wraps naturally
    localparam int PTR_W     = 6;
    localparam int MEM_BYTES = 1 << PTR_W;

    // Clock and calendar bytes 0..7 live in flops
    localparam int CLK_IDX_W = 3;
    localparam int CLK_BYTES = 1 << CLK_IDX_W;

    // Device selection
    localparam logic [7:0] DEVICE_ADDRESS = 8'hd0;
    localparam logic [7:0] SELECT_MASK    = 8'hfe;

    // Operation codes
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_PROBE   = 3'd1;
    localparam logic [2:0] OP_SET_PTR = 3'd2;
    localparam logic [2:0] OP_WRITE   = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    // Clock byte indexes
    localparam logic [CLK_IDX_W-1:0] IDX_SEC   = 3'd0;
    localparam logic [CLK_IDX_W-1:0] IDX_MIN   = 3'd1;
    localparam logic [CLK_IDX_W-1:0] IDX_HOUR  = 3'd2;
    localparam logic [CLK_IDX_W-1:0] IDX_WDAY  = 3'd3;
    localparam logic [CLK_IDX_W-1:0] IDX_DATE  = 3'd4;
    localparam logic [CLK_IDX_W-1:0] IDX_MONTH = 3'd5;
    localparam logic [CLK_IDX_W-1:0] IDX_YEAR  = 3'd6;
    localparam logic [CLK_IDX_W-1:0] IDX_CTRL  = 3'd7;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] data_byte;
    } brtc_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       address_match;
    } brtc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DAY,
        ST_DONE
    } brtc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;        // capture accepted beat, launch memory read
        logic exec;         // run the operation
        logic day;          // advance weekday and calendar
        logic load_result;  // move result into the output register
    } brtc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic day_carry;    // tick rolled the day over
        logic slot_free;    // output register can take a beat
    } brtc_status_t;

    // Reset image of the clock bytes: halted, weekday/date/month 1, byte 7 = 1
    function automatic logic [7:0] clock_reset(input logic [CLK_IDX_W-1:0] idx);
        logic [7:0] val;
        case (idx)
            IDX_SEC:   val = 8'h80;
            IDX_WDAY:  val = 8'h01;
            IDX_DATE:  val = 8'h01;
            IDX_MONTH: val = 8'h01;
            IDX_CTRL:  val = 8'h01;
            default:   val = 8'h00;
        endcase
        return val;
    endfunction

    // tens * 10 + units, units taken as a full nibble
    function automatic logic [7:0] bcd_to_bin(input logic [3:0] tens, input logic [3:0] units);
        return 8'({tens, 3'b000}) + 8'({tens, 1'b0}) + 8'(units);
    endfunction

    // Binary below 100 to two BCD digits; tens by reciprocal multiply
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] x);
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 14'(x) * 14'd103;
        tens  = prod[13:10];
        units = x - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

endpackage

// File: design/brtc_ram.sv
// ---------------------------------------------------------------------------
// brtc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module brtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/brtc_ctrl.sv
// ---------------------------------------------------------------------------
// brtc_ctrl
// Sequencer: accepts one beat, runs it through the datapath, hands off result.
// ---------------------------------------------------------------------------
module brtc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  brtc_pkg::brtc_status_t status,
    output brtc_pkg::brtc_cmd_t    cmd
);

    brtc_pkg::brtc_state_t state_reg;
    brtc_pkg::brtc_state_t state_next;

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= brtc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            brtc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = brtc_pkg::ST_EXEC;
                end
            end
            brtc_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.day_carry ? brtc_pkg::ST_DAY : brtc_pkg::ST_DONE;
            end
            brtc_pkg::ST_DAY: begin
                cmd.day    = 1'b1;
                state_next = brtc_pkg::ST_DONE;
            end
            brtc_pkg::ST_DONE: begin
                // wait for room in the output register
                if (status.slot_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = brtc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brtc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/brtc_dp.sv
// ---------------------------------------------------------------------------
// brtc_dp
// Datapath: clock bytes, register memory, pointer, BCD carry logic, output.
// ---------------------------------------------------------------------------
module brtc_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  brtc_pkg::brtc_cmd_t    cmd,
    input  brtc_pkg::brtc_in_t     s_data,
    input  logic                  m_ready,
    output brtc_pkg::brtc_status_t status,
    output logic                  m_valid,
    output brtc_pkg::brtc_out_t    m_data
);

    localparam logic [7:0] SEC_LIMIT  = 8'd60;
    localparam logic [7:0] H24_LIMIT  = 8'd24;
    localparam logic [7:0] H12_LIMIT  = 8'd12;
    localparam logic [7:0] H12_TWICE  = 8'd24;
    localparam logic [7:0] MONTH_LAST = 8'd12;
    localparam logic [7:0] YEAR_LAST  = 8'd99;
    localparam logic [7:0] YEAR_HUND  = 8'd100;

    // Captured beat and pending result
    logic [2:0]          op_reg;
    logic [7:0]          data_reg;
    brtc_pkg::brtc_out_t res_reg;
    brtc_pkg::brtc_out_t res_next;

    // Pointer, clock bytes, memory valid bits, output register
    logic [brtc_pkg::PTR_W-1:0]     ptr_reg;
    logic [brtc_pkg::PTR_W-1:0]     ptr_next;
    logic [7:0]                     bank_reg  [brtc_pkg::CLK_BYTES];
    logic [7:0]                     bank_next [brtc_pkg::CLK_BYTES];
    logic [brtc_pkg::MEM_BYTES-1:0] valid_reg;
    logic                           m_valid_reg;
    brtc_pkg::brtc_out_t            m_data_reg;

    logic       in_bank;
    logic       ram_we;
    logic [7:0] ram_rdata;
    logic [7:0] read_byte;
    logic       match;

    // Time-of-day terms
    logic       halt;
    logic [7:0] sec_inc, sec_mod, min_inc, min_mod;
    logic       sec_wrap, min_wrap;
    logic [7:0] h12_bin, h12_mod, h12_new;
    logic       h12_one, pm_new, carry12;
    logic [7:0] h24_inc, h24_mod;
    logic       carry24, hour_carry;
    logic [7:0] sec_bcd, min_bcd, h12_bcd, h24_bcd;

    // Calendar terms
    logic [2:0] wd_units;
    logic [2:0] wd_new;
    logic [7:0] year_bin, month_bin, date_bin, month_len;
    logic [7:0] year_new, month_new, date_new;
    logic [7:0] year_bcd, month_bcd, date_bcd;
    logic       year_hi;
    logic [7:0] year_low, year_low_bcd;

    assign in_bank = (ptr_reg[brtc_pkg::PTR_W-1:brtc_pkg::CLK_IDX_W] == '0);
    assign ram_we  = cmd.exec && (op_reg == brtc_pkg::OP_WRITE) && !in_bank;

    brtc_ram #(
        .WIDTH (8),
        .DEPTH (brtc_pkg::MEM_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ptr_reg),
        .wr_data (data_reg),
        .rd_en   (cmd.latch),
        .rd_addr (ptr_reg),
        .rd_data (ram_rdata)
    );

    // Select read byte: clock bytes, written memory, or reset zero
    always_comb begin
        if (in_bank) begin
            read_byte = bank_reg[ptr_reg[brtc_pkg::CLK_IDX_W-1:0]];
        end else if (valid_reg[ptr_reg]) begin
            read_byte = ram_rdata;
        end else begin
            read_byte = 8'h00;
        end
    end

    // Probe: own address or general call, bit 0 ignored
    assign match = ((data_reg & brtc_pkg::SELECT_MASK)
                    == (brtc_pkg::DEVICE_ADDRESS & brtc_pkg::SELECT_MASK))
                || ((data_reg & brtc_pkg::SELECT_MASK) == 8'h00);

    // Seconds and minutes
    always_comb begin
        halt     = bank_reg[brtc_pkg::IDX_SEC][7];
        sec_inc  = brtc_pkg::bcd_to_bin({1'b0, bank_reg[brtc_pkg::IDX_SEC][6:4]},
                                        bank_reg[brtc_pkg::IDX_SEC][3:0]) + 8'd1;
        sec_wrap = (sec_inc >= SEC_LIMIT);
        sec_mod  = sec_wrap ? sec_inc - SEC_LIMIT : sec_inc;
        sec_bcd  = brtc_pkg::bin_to_bcd(sec_mod[6:0]);
        min_inc  = brtc_pkg::bcd_to_bin({1'b0, bank_reg[brtc_pkg::IDX_MIN][6:4]},
                                        bank_reg[brtc_pkg::IDX_MIN][3:0]) + 8'd1;
        min_wrap = (min_inc >= SEC_LIMIT);
        min_mod  = min_wrap ? min_inc - SEC_LIMIT : min_inc;
        min_bcd  = brtc_pkg::bin_to_bcd(min_mod[6:0]);
    end

    // Hours: 12h counts 1..12 with PM toggle at 1, 24h wraps at 24
    always_comb begin
        h12_bin = brtc_pkg::bcd_to_bin({3'b000, bank_reg[brtc_pkg::IDX_HOUR][4]},
                                       bank_reg[brtc_pkg::IDX_HOUR][3:0]);
        if (h12_bin >= H12_TWICE) begin
            h12_mod = h12_bin - H12_TWICE;
        end else if (h12_bin >= H12_LIMIT) begin
            h12_mod = h12_bin - H12_LIMIT;
        end else begin
            h12_mod = h12_bin;
        end
        h12_new = h12_mod + 8'd1;
        h12_one = (h12_new == 8'd1);
        pm_new  = bank_reg[brtc_pkg::IDX_HOUR][5] ^ h12_one;
        carry12 = h12_one && !pm_new;
        h12_bcd = brtc_pkg::bin_to_bcd(h12_new[6:0]);

        h24_inc = brtc_pkg::bcd_to_bin({2'b00, bank_reg[brtc_pkg::IDX_HOUR][5:4]},
                                       bank_reg[brtc_pkg::IDX_HOUR][3:0]) + 8'd1;
        carry24 = (h24_inc >= H24_LIMIT);
        h24_mod = carry24 ? h24_inc - H24_LIMIT : h24_inc;
        h24_bcd = brtc_pkg::bin_to_bcd(h24_mod[6:0]);

        hour_carry = bank_reg[brtc_pkg::IDX_HOUR][6] ? carry12 : carry24;
    end

    // Weekday, date, month, year
    always_comb begin
        wd_units  = bank_reg[brtc_pkg::IDX_WDAY][2:0];
        wd_new    = ((wd_units == 3'd7) ? 3'd0 : wd_units) + 3'd1;
        year_bin  = brtc_pkg::bcd_to_bin(bank_reg[brtc_pkg::IDX_YEAR][7:4],
                                         bank_reg[brtc_pkg::IDX_YEAR][3:0]);
        month_bin = brtc_pkg::bcd_to_bin({3'b000, bank_reg[brtc_pkg::IDX_MONTH][4]},
                                         bank_reg[brtc_pkg::IDX_MONTH][3:0]);
        date_bin  = brtc_pkg::bcd_to_bin({2'b00, bank_reg[brtc_pkg::IDX_DATE][5:4]},
                                         bank_reg[brtc_pkg::IDX_DATE][3:0]);
        case (month_bin)
            8'd2:    month_len = (year_bin[1:0] == 2'b00) ? 8'd29 : 8'd28;
            8'd4,
            8'd6,
            8'd9,
            8'd11:   month_len = 8'd30;
            default: month_len = 8'd31;
        endcase
        year_new  = year_bin;
        month_new = month_bin;
        if (date_bin >= month_len) begin
            date_new = 8'd1;
            if (month_bin >= MONTH_LAST) begin
                month_new = 8'd1;
                year_new  = (year_bin >= YEAR_LAST) ? 8'd0 : year_bin + 8'd1;
            end else begin
                month_new = month_bin + 8'd1;
            end
        end else begin
            date_new = date_bin + 8'd1;
        end
        date_bcd  = brtc_pkg::bin_to_bcd(date_new[6:0]);
        month_bcd = brtc_pkg::bin_to_bcd(month_new[6:0]);
        // A kept year of 100 or more writes back its tens count modulo 16
        year_hi      = (year_new >= YEAR_HUND);
        year_low     = year_hi ? year_new - YEAR_HUND : year_new;
        year_low_bcd = brtc_pkg::bin_to_bcd(year_low[6:0]);
        year_bcd     = {year_low_bcd[7:4] + (year_hi ? 4'd10 : 4'd0), year_low_bcd[3:0]};
    end

    // Next clock bytes, pointer and pending result
    always_comb begin
        for (int i = 0; i < brtc_pkg::CLK_BYTES; i++) begin
            bank_next[i] = bank_reg[i];
        end
        ptr_next = ptr_reg;
        res_next = res_reg;

        if (cmd.exec) begin
            res_next = '0;
            case (op_reg)
                brtc_pkg::OP_TICK: begin
                    if (!halt) begin
                        bank_next[brtc_pkg::IDX_SEC] = {bank_reg[brtc_pkg::IDX_SEC][7],
                                                        sec_bcd[6:0]};
                        if (sec_wrap) begin
                            bank_next[brtc_pkg::IDX_MIN] = {bank_reg[brtc_pkg::IDX_MIN][7],
                                                            min_bcd[6:0]};
                            if (min_wrap) begin
                                if (bank_reg[brtc_pkg::IDX_HOUR][6]) begin
                                    bank_next[brtc_pkg::IDX_HOUR] =
                                        {bank_reg[brtc_pkg::IDX_HOUR][7:6], pm_new,
                                         h12_bcd[4:0]};
                                end else begin
                                    bank_next[brtc_pkg::IDX_HOUR] =
                                        {bank_reg[brtc_pkg::IDX_HOUR][7:6], h24_bcd[5:0]};
                                end
                            end
                        end
                    end
                end
                brtc_pkg::OP_PROBE: begin
                    res_next.address_match = match;
                end
                brtc_pkg::OP_SET_PTR: begin
                    ptr_next = data_reg[brtc_pkg::PTR_W-1:0];
                end
                brtc_pkg::OP_WRITE: begin
                    if (in_bank) begin
                        bank_next[ptr_reg[brtc_pkg::CLK_IDX_W-1:0]] = data_reg;
                    end
                    ptr_next = ptr_reg + 1'b1;
                end
                brtc_pkg::OP_READ: begin
                    res_next.read_data = read_byte;
                    ptr_next           = ptr_reg + 1'b1;
                end
                default: begin
                    res_next = '0;
                end
            endcase
        end

        // Day rollover: time bytes already updated, calendar bytes untouched so far
        if (cmd.day) begin
            bank_next[brtc_pkg::IDX_WDAY]  = {bank_reg[brtc_pkg::IDX_WDAY][7:3], wd_new};
            bank_next[brtc_pkg::IDX_DATE]  = {bank_reg[brtc_pkg::IDX_DATE][7:6],
                                              date_bcd[5:0]};
            bank_next[brtc_pkg::IDX_MONTH] = {bank_reg[brtc_pkg::IDX_MONTH][7:5],
                                              month_bcd[4:0]};
            bank_next[brtc_pkg::IDX_YEAR]  = year_bcd;
        end
    end

    // Capture beat and pending result
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= s_data.opcode;
            data_reg <= s_data.data_byte;
        end
        res_reg <= res_next;
        if (cmd.load_result) begin
            m_data_reg <= res_reg;
        end
    end

    // Control state: pointer, clock bytes, valid bits, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < brtc_pkg::CLK_BYTES; i++) begin
                bank_reg[i] <= brtc_pkg::clock_reset(brtc_pkg::CLK_IDX_W'(i));
            end
        end else begin
            ptr_reg <= ptr_next;
            for (int i = 0; i < brtc_pkg::CLK_BYTES; i++) begin
                bank_reg[i] <= bank_next[i];
            end
            if (ram_we) begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.load_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.day_carry = cmd.exec && (op_reg == brtc_pkg::OP_TICK) && !halt
                              && sec_wrap && min_wrap && hour_carry;
    assign status.slot_free = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;

endmodule

// File: design/bcd_rtc_with_register_memory.sv
// ---------------------------------------------------------------------------
// bcd_rtc_with_register_memory
// BCD clock and calendar behind a wrapping 64-byte register memory.
// ---------------------------------------------------------------------------
//
//   channel | direction | ports                      | beat carries
//   --------+-----------+----------------------------+---------------------------
//   s_      | in        | s_valid, s_ready, s_data   | opcode, data_byte
//   m_      | out       | m_valid, m_ready, m_data   | read_data, address_match
//
// One beat at a time: after the accepting edge the beat passes through EXEC, then
// DAY for a tick that rolls the day over (the calendar update takes its own step),
// then DONE, which loads the result; no new beat is taken before that load.
// Reads go through the memory's registered read port, launched at accept.
// Reset: synchronous, low aresetn; no clearing pass.
// A stalled m_ side holds its result; the next beat is still taken, then waits
// finished with the input closed until the held result leaves.
// ---------------------------------------------------------------------------
`include "bcd_rtc_with_register_memory_assert.svh"

module bcd_rtc_with_register_memory (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  brtc_pkg::brtc_in_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output brtc_pkg::brtc_out_t m_data
);

    brtc_pkg::brtc_cmd_t    cmd;
    brtc_pkg::brtc_status_t status;

    brtc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    brtc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .m_ready (m_ready),
        .status  (status),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    // Never overwrite a result still waiting on the m_ side
    `BRTC_ASSERT_SAME(a_load_free, aclk, aresetn, cmd.load_result, status.slot_free, "lost result")
    // An accepted beat closes the input until it completes
    `BRTC_ASSERT_NEXT(a_one_beat, aclk, aresetn, s_valid && s_ready, !s_ready, "second beat accepted")
    // Calendar step only right after a tick execution
    `BRTC_ASSERT_SAME(a_day_after_exec, aclk, aresetn, cmd.day, $past(cmd.exec), "stray day step")

endmodule

// File: tb/tb_bcd_rtc_with_register_memory.sv
// ---------------------------------------------------------------------------
// tb_bcd_rtc_with_register_memory
// Self-checking bench for the BCD clock with its wrapping register memory.
// A directed table covers power-up contents, probes, spare opcodes, pointer
// wrap and a full calendar rollover. Random clock images near rollover points,
// memory bursts and opcode noise follow. Every result beat is compared with a
// typed value or a behavioral model of the clock and memory, with random stalls on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bcd_rtc_with_register_memory;

    localparam int unsigned BEAT_TARGET = 2000;
    localparam int unsigned HOLD_AT     = 500;
    localparam int unsigned DRAIN_AT    = 1100;
    localparam int unsigned QUIET_AT    = 1750;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned DRAIN_TAIL  = 8;
    localparam int unsigned DIR_ROWS    = 26;

    // Opcodes the block does not decode
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [7:0] HALT_BIT   = 8'h80;
    localparam logic [7:0] MODE12_BIT = 8'h40;
    localparam logic [7:0] PM_BIT     = 8'h20;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       fixed;
        logic [7:0] rd;
        logic       match;
    } dir_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    brtc_pkg::brtc_in_t  s_data;
    logic                m_valid;
    logic                m_ready;
    brtc_pkg::brtc_out_t m_data;

    // Model state
    logic [7:0]                 rtc_mem [brtc_pkg::MEM_BYTES];
    logic [brtc_pkg::PTR_W-1:0] rtc_ptr;

    brtc_pkg::brtc_out_t rtc_expect_q [$];
    int unsigned         err_count   = 0;
    int unsigned         beats_sent  = 0;
    bit                  idle_en     = 1'b1;
    bit                  sender_idle = 1'b1;
    bit                  hold_req    = 1'b0;

    bcd_rtc_with_register_memory u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Clock and memory model
    // -----------------------------------------------------------------------
    function automatic int unsigned bcd_val(input logic [7:0] v, input logic [3:0] tens_mask);
        int unsigned t;
        int unsigned u;
        t = v[7:4] & tens_mask;
        u = v[3:0];
        return t * 10 + u;
    endfunction

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return 8'(((v / 10) << 4) + (v % 10));
    endfunction

    function automatic void set_field(input int idx, input logic [7:0] mask,
                                      input logic [7:0] val);
        rtc_mem[idx] = (rtc_mem[idx] & ~mask) | (val & mask);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned month,
                                                  input int unsigned year);
        if (month == 2)
            return (year % 4 == 0) ? 29 : 28;
        if (month == 4 || month == 6 || month == 9 || month == 11)
            return 30;
        return 31;
    endfunction

    function automatic void rtc_model_reset();
        for (int i = 0; i < brtc_pkg::MEM_BYTES; i++)
            rtc_mem[i] = 8'h00;
        rtc_mem[brtc_pkg::IDX_SEC]   = HALT_BIT;
        rtc_mem[brtc_pkg::IDX_WDAY]  = 8'h01;
        rtc_mem[brtc_pkg::IDX_DATE]  = 8'h01;
        rtc_mem[brtc_pkg::IDX_MONTH] = 8'h01;
        rtc_mem[brtc_pkg::IDX_CTRL]  = 8'h01;
        rtc_ptr = '0;
    endfunction

    // Step weekday, date, month and year by one day
    function automatic void calendar_advance();
        int unsigned wd;
        int unsigned year;
        int unsigned month;
        int unsigned date;
        wd    = bcd_val(rtc_mem[brtc_pkg::IDX_WDAY] & 8'h07, 4'h0) % 7 + 1;
        year  = bcd_val(rtc_mem[brtc_pkg::IDX_YEAR], 4'hf);
        month = bcd_val(rtc_mem[brtc_pkg::IDX_MONTH] & 8'h1f, 4'h1);
        date  = bcd_val(rtc_mem[brtc_pkg::IDX_DATE] & 8'h3f, 4'h3);
        if (date >= days_in_month(month, year)) begin
            date = 1;
            if (month >= 12) begin
                month = 1;
                year  = (year >= 99) ? 0 : year + 1;
            end else begin
                month = month + 1;
            end
        end else begin
            date = date + 1;
        end
        set_field(brtc_pkg::IDX_WDAY, 8'h07, 8'(wd));
        set_field(brtc_pkg::IDX_DATE, 8'h3f, to_bcd(date));
        set_field(brtc_pkg::IDX_MONTH, 8'h1f, to_bcd(month));
        set_field(brtc_pkg::IDX_YEAR, 8'hff, to_bcd(year));
    endfunction

    // One-second tick: seconds carry into minutes, hours, then the calendar
    function automatic void clock_tick();
        int unsigned v;
        logic [7:0]  h;
        logic [7:0]  pm;
        bit          carry;
        if ((rtc_mem[brtc_pkg::IDX_SEC] & HALT_BIT) != 0)
            return;
        v = bcd_val(rtc_mem[brtc_pkg::IDX_SEC] & 8'h7f, 4'h7) + 1;
        set_field(brtc_pkg::IDX_SEC, 8'h7f, to_bcd(v % 60));
        if (v < 60)
            return;
        v = bcd_val(rtc_mem[brtc_pkg::IDX_MIN] & 8'h7f, 4'h7) + 1;
        set_field(brtc_pkg::IDX_MIN, 8'h7f, to_bcd(v % 60));
        if (v < 60)
            return;
        h = rtc_mem[brtc_pkg::IDX_HOUR];
        if ((h & MODE12_BIT) != 0) begin
            pm    = h & PM_BIT;
            carry = 1'b0;
            v     = bcd_val(h & 8'h3f, 4'h1) % 12 + 1;
            // PM flips going to 1 o'clock; the day moves on when it clears
            if (v == 1) begin
                pm    = pm ^ PM_BIT;
                carry = (pm == 8'h00);
            end
            set_field(brtc_pkg::IDX_HOUR, 8'h3f, to_bcd(v) | pm);
            if (!carry)
                return;
        end else begin
            v = bcd_val(h & 8'h3f, 4'h3) + 1;
            set_field(brtc_pkg::IDX_HOUR, 8'h3f, to_bcd(v % 24));
            if (v < 24)
                return;
        end
        calendar_advance();
    endfunction

    function automatic brtc_pkg::brtc_out_t rtc_predict(input brtc_pkg::brtc_in_t beat);
        brtc_pkg::brtc_out_t res;
        res = '0;
        case (beat.opcode)
            brtc_pkg::OP_TICK: begin
                clock_tick();
            end
            brtc_pkg::OP_PROBE: begin
                res.address_match =
                    ((beat.data_byte & brtc_pkg::SELECT_MASK) ==
                     (brtc_pkg::DEVICE_ADDRESS & brtc_pkg::SELECT_MASK)) ||
                    ((beat.data_byte & brtc_pkg::SELECT_MASK) == 8'h00);
            end
            brtc_pkg::OP_SET_PTR: begin
                rtc_ptr = beat.data_byte[brtc_pkg::PTR_W-1:0];
            end
            brtc_pkg::OP_WRITE: begin
                rtc_mem[rtc_ptr] = beat.data_byte;
                rtc_ptr = rtc_ptr + 1'b1;
            end
            brtc_pkg::OP_READ: begin
                res.read_data = rtc_mem[rtc_ptr];
                rtc_ptr = rtc_ptr + 1'b1;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Directed table: expected result typed in where fixed is set
    // -----------------------------------------------------------------------
    function automatic dir_row_t directed_row(input int unsigned n);
        dir_row_t r;
        case (n)
            0:  r = '{brtc_pkg::OP_READ,    8'h00, 1'b1, 8'h80, 1'b0}; // power-up: halted
            1:  r = '{brtc_pkg::OP_TICK,    8'h00, 1'b1, 8'h00, 1'b0}; // halted tick
            2:  r = '{brtc_pkg::OP_READ,    8'h00, 1'b1, 8'h00, 1'b0}; // minutes still zero
            3:  r = '{brtc_pkg::OP_PROBE,   8'hd0, 1'b1, 8'h00, 1'b1};
            4:  r = '{brtc_pkg::OP_PROBE,   8'hd1, 1'b1, 8'h00, 1'b1}; // R/W bit ignored
            5:  r = '{brtc_pkg::OP_PROBE,   8'h01, 1'b1, 8'h00, 1'b1}; // general call
            6:  r = '{brtc_pkg::OP_PROBE,   8'hff, 1'b1, 8'h00, 1'b0};
            7:  r = '{OP_SPARE_5,           8'hff, 1'b1, 8'h00, 1'b0};
            8:  r = '{OP_SPARE_6,           8'haa, 1'b1, 8'h00, 1'b0};
            9:  r = '{OP_SPARE_7,           8'h00, 1'b1, 8'h00, 1'b0};
            10: r = '{brtc_pkg::OP_SET_PTR, 8'hff, 1'b1, 8'h00, 1'b0}; // pointer to last
            11: r = '{brtc_pkg::OP_WRITE,   8'ha5, 1'b1, 8'h00, 1'b0};
            12: r = '{brtc_pkg::OP_READ,    8'h00, 1'b1, 8'h80, 1'b0}; // wrapped to byte 0
            13: r = '{brtc_pkg::OP_SET_PTR, 8'h40, 1'b1, 8'h00, 1'b0}; // 64 wraps to 0
            14: r = '{brtc_pkg::OP_WRITE,   8'h59, 1'b1, 8'h00, 1'b0}; // run, 59 s
            15: r = '{brtc_pkg::OP_WRITE,   8'h59, 1'b1, 8'h00, 1'b0};
            16: r = '{brtc_pkg::OP_WRITE,   8'h72, 1'b1, 8'h00, 1'b0}; // 12h, 12 PM
            17: r = '{brtc_pkg::OP_WRITE,   8'h07, 1'b1, 8'h00, 1'b0};
            18: r = '{brtc_pkg::OP_WRITE,   8'h31, 1'b1, 8'h00, 1'b0};
            19: r = '{brtc_pkg::OP_WRITE,   8'h12, 1'b1, 8'h00, 1'b0};
            20: r = '{brtc_pkg::OP_WRITE,   8'h99, 1'b1, 8'h00, 1'b0};
            21: r = '{brtc_pkg::OP_TICK,    8'h00, 1'b1, 8'h00, 1'b0}; // year rollover
            22: r = '{brtc_pkg::OP_SET_PTR, 8'h00, 1'b1, 8'h00, 1'b0};
            23: r = '{brtc_pkg::OP_READ,    8'h00, 1'b0, 8'h00, 1'b0};
            24: r = '{brtc_pkg::OP_READ,    8'h00, 1'b0, 8'h00, 1'b0};
            default: r = '{brtc_pkg::OP_READ, 8'h00, 1'b0, 8'h00, 1'b0};
        endcase
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // Offer one beat, hold it until accepted, then log its expected result.
    // Valid stays high on return; the caller either offers again or drops it.
    task automatic send_beat(input brtc_pkg::brtc_in_t beat, input bit use_fixed,
                             input brtc_pkg::brtc_out_t fixed_out);
        brtc_pkg::brtc_out_t want;
        if (sender_idle && idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        want = rtc_predict(beat);
        if (use_fixed)
            want = fixed_out;
        rtc_expect_q.push_back(want);
        beats_sent++;
    endtask

    task automatic bus_op(input logic [2:0] op, input logic [7:0] d);
        brtc_pkg::brtc_in_t beat;
        beat.opcode    = op;
        beat.data_byte = d;
        send_beat(beat, 1'b0, '0);
    endtask

    // Load a clock image near a rollover, tick it, read all clock bytes back
    task automatic run_clock_case();
        logic [7:0]  img [brtc_pkg::CLK_BYTES];
        int unsigned n_ticks;
        case ($urandom_range(0, 3))
            0:       img[brtc_pkg::IDX_SEC] = 8'h59;
            1:       img[brtc_pkg::IDX_SEC] = 8'h58;
            2:       img[brtc_pkg::IDX_SEC] = to_bcd($urandom_range(0, 59));
            default: img[brtc_pkg::IDX_SEC] = 8'($urandom_range(0, 127));
        endcase
        if ($urandom_range(0, 7) == 0)
            img[brtc_pkg::IDX_SEC] = img[brtc_pkg::IDX_SEC] | HALT_BIT;
        img[brtc_pkg::IDX_MIN] = ($urandom_range(0, 2) != 0) ? 8'h59 : 8'($urandom);
        case ($urandom_range(0, 6))
            0:       img[brtc_pkg::IDX_HOUR] = 8'h23;
            1:       img[brtc_pkg::IDX_HOUR] = 8'h72;
            2:       img[brtc_pkg::IDX_HOUR] = 8'h52;
            3:       img[brtc_pkg::IDX_HOUR] = 8'h71;
            4:       img[brtc_pkg::IDX_HOUR] = MODE12_BIT | to_bcd($urandom_range(1, 12)) |
                                     (($urandom_range(0, 1) != 0) ? PM_BIT : 8'h00);
            5:       img[brtc_pkg::IDX_HOUR] = to_bcd($urandom_range(0, 23));
            default: img[brtc_pkg::IDX_HOUR] = 8'($urandom);
        endcase
        img[brtc_pkg::IDX_WDAY] = ($urandom_range(0, 3) != 0) ?
                                  8'($urandom_range(1, 7)) : 8'($urandom);
        case ($urandom_range(0, 5))
            0:       img[brtc_pkg::IDX_DATE] = 8'h28;
            1:       img[brtc_pkg::IDX_DATE] = 8'h29;
            2:       img[brtc_pkg::IDX_DATE] = 8'h30;
            3:       img[brtc_pkg::IDX_DATE] = 8'h31;
            4:       img[brtc_pkg::IDX_DATE] = to_bcd($urandom_range(1, 31));
            default: img[brtc_pkg::IDX_DATE] = 8'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0, 1, 2: img[brtc_pkg::IDX_MONTH] = to_bcd($urandom_range(1, 12));
            3:       img[brtc_pkg::IDX_MONTH] = 8'h12;
            4:       img[brtc_pkg::IDX_MONTH] = 8'h02;
            5:       img[brtc_pkg::IDX_MONTH] = 8'h00;
            default: img[brtc_pkg::IDX_MONTH] = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       img[brtc_pkg::IDX_YEAR] = 8'h99;
            1:       img[brtc_pkg::IDX_YEAR] = to_bcd(4 * $urandom_range(0, 24));
            2, 3:    img[brtc_pkg::IDX_YEAR] = to_bcd($urandom_range(0, 99));
            default: img[brtc_pkg::IDX_YEAR] = 8'($urandom);
        endcase
        img[brtc_pkg::IDX_CTRL] = 8'($urandom);

        // Upper pointer bits are dropped by the block
        bus_op(brtc_pkg::OP_SET_PTR, 8'($urandom_range(0, 3) << brtc_pkg::PTR_W));
        for (int i = 0; i < brtc_pkg::CLK_BYTES; i++)
            bus_op(brtc_pkg::OP_WRITE, img[i]);
        n_ticks = $urandom_range(1, 3);
        repeat (n_ticks) begin
            bus_op(brtc_pkg::OP_TICK, 8'($urandom));
            if ($urandom_range(0, 3) == 0)
                bus_op(brtc_pkg::OP_PROBE, 8'($urandom));
        end
        bus_op(brtc_pkg::OP_SET_PTR, 8'h00);
        for (int i = 0; i < brtc_pkg::CLK_BYTES; i++)
            bus_op(brtc_pkg::OP_READ, 8'($urandom));
    endtask

    // Write a burst anywhere in memory, then read it back
    task automatic run_memory_case();
        logic [7:0]  start;
        int unsigned n;
        start = 8'($urandom);
        n     = $urandom_range(1, 12);
        bus_op(brtc_pkg::OP_SET_PTR, start);
        repeat (n) bus_op(brtc_pkg::OP_WRITE, 8'($urandom));
        bus_op(brtc_pkg::OP_SET_PTR, start);
        repeat (n) bus_op(brtc_pkg::OP_READ, 8'($urandom));
    endtask

    // Any opcode with any byte; probes lean toward selecting addresses
    task automatic run_noise_case();
        logic [2:0] op;
        logic [7:0] d;
        repeat ($urandom_range(1, 8)) begin
            op = 3'($urandom);
            d  = 8'($urandom);
            if (op == brtc_pkg::OP_PROBE && $urandom_range(0, 1) == 0)
                d = (($urandom_range(0, 1) != 0) ? brtc_pkg::DEVICE_ADDRESS : 8'h00) |
                    8'($urandom_range(0, 1));
            bus_op(op, d);
        end
    endtask

    // -----------------------------------------------------------------------
    // Result side: compare, then pick next ready
    // -----------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        err_count++;
    endtask

    task automatic check_result(input brtc_pkg::brtc_out_t got);
        brtc_pkg::brtc_out_t want;
        if (rtc_expect_q.size() == 0) begin
            flag_mismatch("unexpected beat", 32'(got), 0);
        end else begin
            want = rtc_expect_q.pop_front();
            if (got.read_data !== want.read_data)
                flag_mismatch("read_data", 32'(got.read_data), 32'(want.read_data));
            if (got.address_match !== want.address_match)
                flag_mismatch("address_match", 32'(got.address_match),
                              32'(want.address_match));
        end
    endtask

    initial begin : result_side
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_result(m_data);
            // Long hold-off so the block backs up into its input
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin : stimulus
        dir_row_t            r;
        brtc_pkg::brtc_in_t  beat;
        brtc_pkg::brtc_out_t typed;
        bit                  hold_done;
        bit                  drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        aresetn <= 1'b0;
        rtc_model_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int unsigned row = 0; row < DIR_ROWS; row++) begin
            r = directed_row(row);
            beat.opcode         = r.op;
            beat.data_byte      = r.data;
            typed.read_data     = r.rd;
            typed.address_match = r.match;
            send_beat(beat, r.fixed, typed);
        end

        // Random sequences
        while (beats_sent < BEAT_TARGET) begin
            sender_idle = ($urandom_range(0, 2) != 0);
            if (!hold_done && beats_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            // Pause the input until every result is out
            if (!drain_done && beats_sent >= DRAIN_AT) begin
                drain_done = 1'b1;
                s_valid <= 1'b0;
                while (rtc_expect_q.size() != 0) @(posedge aclk);
            end
            if (beats_sent >= QUIET_AT)
                idle_en = 1'b0;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: run_clock_case();
                6, 7:             run_memory_case();
                default:          run_noise_case();
            endcase
        end

        // Drain and finish
        s_valid <= 1'b0;
        while (rtc_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (err_count == 0 && rtc_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
